/* rtl/w3gb_pkg.sv */
// ----------------------------------------------------------------------------
// w3gb_pkg
// Shared types and constants for the weighted 3d grid binning block.
// ----------------------------------------------------------------------------
package w3gb_pkg;

  localparam int BINS_X_DEF  = 16;
  localparam int BINS_Y_DEF  = 16;
  localparam int BINS_Z_DEF  = 16;

  localparam int STORE_DEPTH = 4096;
  localparam int IDX_W       = 12;
  localparam int SUM_W       = 48;
  localparam int COORD_W     = 32;
  localparam int REG_W       = 31;
  localparam int CFG_IDX_W   = 3;

  localparam logic [REG_W-1:0] STEP_RST   = 31'd4096;
  localparam logic [REG_W-1:0] EXTENT_RST = 31'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 3'd5;

  // command codes
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_weight;
    logic [IDX_W-1:0]          read_cell;
  } w3gb_in_t;

  typedef struct packed {
    logic                    accepted;
    logic                    out_of_range;
    logic [IDX_W-1:0]        cell_index;
    logic signed [SUM_W-1:0] cell_sum;
  } w3gb_out_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_LIN1,
    ST_LIN2,
    ST_RD,
    ST_UPD,
    ST_PUSH
  } w3gb_state_t;

endpackage

/* rtl/weighted_3d_grid_binning.sv */
// ----------------------------------------------------------------------------
// weighted_3d_grid_binning
// Bins weighted 3d points into a grid of signed 48-bit accumulators held in
// one synchronous memory; read commands return a cell's sum and clear it.
// ----------------------------------------------------------------------------
// One word is worked on at a time. An accumulate word that lands in the grid
// passes the window check, the bit-serial dividers that find the cell along
// each axis, with QBITS quotient bits where QBITS is clog2 of the largest bin
// count (4 for 16 bins), the index sums, memory read, update and result; only
// then is the next word taken. A read-and-clear word passes check, memory
// read, update and result, a point outside the window check and result. A
// finished result sits in the output register while the next word is taken.
// After reset the block sweeps all 4096 words of the accumulator memory to
// zero and stalls input until done; configuration writes are always taken.
module weighted_3d_grid_binning
  import w3gb_pkg::*;
#(
  parameter int BINS_X = BINS_X_DEF,
  parameter int BINS_Y = BINS_Y_DEF,
  parameter int BINS_Z = BINS_Z_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  w3gb_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output w3gb_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int BMAX_XY = (BINS_X > BINS_Y) ? BINS_X : BINS_Y;
  localparam int BMAX    = (BMAX_XY > BINS_Z) ? BMAX_XY : BINS_Z;
  localparam int QBITS   = (BMAX > 1) ? $clog2(BMAX) : 1;
  localparam int CW      = (QBITS > 1) ? $clog2(QBITS) : 1;
  localparam int DW      = REG_W + QBITS;
  localparam int TW      = $clog2(BINS_X * BINS_Y) + 1;
  localparam int LW      = $clog2(BINS_X * BINS_Y * BINS_Z) + 1;

  w3gb_state_t state_r, state_nxt;

  logic [REG_W-1:0] step_r [3];
  logic [REG_W-1:0] ext_r  [3];

  w3gb_in_t  item_r, item_nxt;
  logic [REG_W-1:0] rem_r [3];
  logic [REG_W-1:0] rem_nxt [3];
  logic [DW-1:0]    div_r [3];
  logic [DW-1:0]    div_nxt [3];
  logic [QBITS-1:0] q_r [3];
  logic [QBITS-1:0] q_nxt [3];
  logic [QBITS:0]   q_shift [3];
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [TW-1:0]    t_r, t_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  w3gb_out_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  w3gb_out_t        out_data_r, out_data_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic signed [COORD_W-1:0] coord [3];
  logic [2:0]       in_win;
  logic [2:0]       too_big;
  logic [2:0]       ge;
  logic [2:0]       bin_oor;
  logic [LW-1:0]    lin;
  logic [31:0]      lin32;
  logic signed [SUM_W-1:0] weight_ext;

  // accumulator memory
  logic [SUM_W-1:0] mem [STORE_DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [SUM_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[idx_r];
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        step_r[a] <= STEP_RST;
        ext_r[a]  <= EXTENT_RST;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP_X:   step_r[0] <= cfg_data;
        CFG_STEP_Y:   step_r[1] <= cfg_data;
        CFG_STEP_Z:   step_r[2] <= cfg_data;
        CFG_EXTENT_X: ext_r[0]  <= cfg_data;
        CFG_EXTENT_Y: ext_r[1]  <= cfg_data;
        CFG_EXTENT_Z: ext_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coord[0]   = item_r.point_x;
  assign coord[1]   = item_r.point_y;
  assign coord[2]   = item_r.point_z;
  assign weight_ext = SUM_W'(item_r.point_weight);

  // per-axis window test, quotient overflow and one restoring division step
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_win[a]  = (coord[a] > 0) && (coord[a] < $signed({1'b0, ext_r[a]}));
      too_big[a] = {{QBITS{1'b0}}, coord[a][REG_W-1:0]} >= {step_r[a], {QBITS{1'b0}}};
      ge[a]      = {{QBITS{1'b0}}, rem_r[a]} >= div_r[a];
      q_shift[a] = {q_r[a], ge[a]};
    end
    bin_oor[0] = 32'(q_r[0]) >= 32'(BINS_X);
    bin_oor[1] = 32'(q_r[1]) >= 32'(BINS_Y);
    bin_oor[2] = 32'(q_r[2]) >= 32'(BINS_Z);
    lin   = LW'(q_r[2]) + LW'(t_r) * LW'(BINS_Z);
    lin32 = 32'(lin);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int a = 0; a < 3; a++) begin
      rem_nxt[a] = rem_r[a];
      div_nxt[a] = div_r[a];
      q_nxt[a]   = q_r[a];
    end
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '0;
    mem_re    = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        res_nxt = '0;
        if (item_r.cmd == CMD_READ) begin
          idx_nxt   = item_r.read_cell;
          state_nxt = ST_RD;
        end else if (in_win != 3'b111) begin
          state_nxt = ST_PUSH;
        end else if (too_big != 3'b000) begin
          // quotient needs more than QBITS bits on some axis
          res_nxt.out_of_range = 1'b1;
          state_nxt            = ST_PUSH;
        end else begin
          for (int a = 0; a < 3; a++) begin
            rem_nxt[a] = coord[a][REG_W-1:0];
            div_nxt[a] = {step_r[a], {QBITS{1'b0}}} >> 1;
            q_nxt[a]   = '0;
          end
          cnt_nxt   = CW'(QBITS - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        for (int a = 0; a < 3; a++) begin
          rem_nxt[a] = ge[a] ? (rem_r[a] - div_r[a][REG_W-1:0]) : rem_r[a];
          div_nxt[a] = div_r[a] >> 1;
          q_nxt[a]   = q_shift[a][QBITS-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_LIN1;
        end
      end
      ST_LIN1: begin
        if (bin_oor != 3'b000) begin
          res_nxt.out_of_range = 1'b1;
          state_nxt            = ST_PUSH;
        end else begin
          t_nxt     = TW'(q_r[1]) + TW'(q_r[0]) * TW'(BINS_Y);
          state_nxt = ST_LIN2;
        end
      end
      ST_LIN2: begin
        if (lin32 >= 32'(STORE_DEPTH)) begin
          res_nxt.out_of_range = 1'b1;
          state_nxt            = ST_PUSH;
        end else begin
          idx_nxt   = lin32[IDX_W-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        res_nxt.accepted     = 1'b1;
        res_nxt.out_of_range = 1'b0;
        res_nxt.cell_index   = idx_r;
        mem_we               = 1'b1;
        mem_waddr            = idx_r;
        if (item_r.cmd == CMD_READ) begin
          res_nxt.cell_sum = mem_rdata_r;
          mem_wdata        = '0;
        end else begin
          res_nxt.cell_sum = mem_rdata_r + weight_ext;
          mem_wdata        = mem_rdata_r + weight_ext;
        end
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    t_r        <= t_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    for (int a = 0; a < 3; a++) begin
      rem_r[a] <= rem_nxt[a];
      div_r[a] <= div_nxt[a];
      q_r[a]   <= q_nxt[a];
    end
  end

endmodule
